/* rtl/gcb_pkg.sv */
// Package for the graph colouring block: sizes, codes and the transfer structs.
// Depends on nothing; imported by the top level and the checker.
package gcb_pkg;

    localparam int MAX_NODES    = 32;
    localparam int MAX_COLORS   = 16;
    localparam int RESULT_LIMIT = 32;
    localparam int NODE_LIMIT   = (MAX_NODES < RESULT_LIMIT) ? MAX_NODES : RESULT_LIMIT;

    localparam int NODE_W  = (NODE_LIMIT > 1) ? $clog2(NODE_LIMIT) : 1;
    localparam int COLOR_W = $clog2(MAX_COLORS);

    localparam int NODE_FIELD_W  = 5;
    localparam int COLOR_FIELD_W = 4;
    localparam int NODE_CFG_W    = 6;
    localparam int COLOR_CFG_W   = 5;
    localparam int CFG_DATA_W    = 6;

    typedef enum logic [1:0] {
        KIND_EDGE  = 2'd0,
        KIND_SOLVE = 2'd1,
        KIND_CLEAR = 2'd2
    } t_kind;

    typedef enum logic [0:0] {
        CFG_NODE_COUNT  = 1'b0,
        CFG_COLOR_COUNT = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        t_kind                   kind;
        logic [NODE_FIELD_W-1:0] node_a;
        logic [NODE_FIELD_W-1:0] node_b;
    } t_in_item;

    typedef struct packed {
        logic [NODE_FIELD_W-1:0]  node_index;
        logic [COLOR_FIELD_W-1:0] node_color;
        logic                     found;
        logic                     last;
    } t_out_item;

endpackage

/* rtl/graph_coloring_backtrack.sv */
// Graph m-colouring by depth-first backtracking over an adjacency bit matrix.
// Edge and clear transfers keep the block in ST_IDLE, so it stays ready for the next.
// Solve: ST_SEARCH makes one colour test or backtrack step at a time on the shared conflict
// unit, then spots the end; ST_EMIT then gives one result per cycle while the sink is ready.
// Input is stalled from solve accept until the last result is in the output register.
// Reset (i_rst_n low, synchronous) clears the matrix, sets both counts to 1, goes idle.
module graph_coloring_backtrack
    import gcb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  t_cfg_reg              i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_data
);

    typedef logic [NODE_W:0]  t_npos;
    typedef logic [COLOR_W:0] t_ncol;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SEARCH = 3'b010,
        ST_EMIT   = 3'b100
    } t_state;

    t_state                  r_state, n_state;
    logic [NODE_CFG_W-1:0]   r_node_count;
    logic [COLOR_CFG_W-1:0]  r_color_count;
    logic [NODE_LIMIT-1:0]   r_adj [NODE_LIMIT];
    logic [COLOR_W-1:0]      r_assign [NODE_LIMIT];
    logic [NODE_LIMIT-1:0]   r_assigned;
    t_npos                   r_pos, n_pos;
    t_ncol                   r_color, n_color;
    logic                    r_found, n_found;
    logic                    r_out_valid, n_out_valid;
    t_out_item               r_out, n_out;

    t_npos                   eff_n;
    t_ncol                   eff_m;
    logic                    in_xfer;
    logic                    edge_we, adj_clr, asg_start, asg_we, asg_drop;
    logic [NODE_W-1:0]       pos_idx, rd_idx;
    t_npos                   pos_m1;
    logic [COLOR_W-1:0]      rd_color;
    logic [NODE_LIMIT-1:0]   cur_row;
    logic                    conflict;
    logic                    out_free;

    // effective counts, saturated as the search needs them
    always_comb begin
        if (r_node_count == '0) begin
            eff_n = t_npos'(1);
        end else if (r_node_count > NODE_CFG_W'(NODE_LIMIT)) begin
            eff_n = t_npos'(NODE_LIMIT);
        end else begin
            eff_n = t_npos'(r_node_count);
        end
        if (r_color_count > COLOR_CFG_W'(MAX_COLORS)) begin
            eff_m = t_ncol'(MAX_COLORS);
        end else begin
            eff_m = t_ncol'(r_color_count);
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);
    assign in_xfer    = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    assign pos_idx  = r_pos[NODE_W-1:0];
    assign pos_m1   = r_pos - 1'b1;
    // single read port: the node being emitted, or the one we step back to
    assign rd_idx   = (r_state == ST_EMIT) ? pos_idx : pos_m1[NODE_W-1:0];
    assign rd_color = r_assign[rd_idx];
    assign cur_row  = r_adj[pos_idx];

    // shared conflict unit: does any assigned neighbour hold the trial colour
    always_comb begin
        conflict = 1'b0;
        for (int i = 0; i < NODE_LIMIT; i++) begin
            conflict = conflict | (cur_row[i] & r_assigned[i]
                                   & (r_assign[i] == r_color[COLOR_W-1:0]));
        end
    end

    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_color     = r_color;
        n_found     = r_found;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        edge_we     = 1'b0;
        adj_clr     = 1'b0;
        asg_start   = 1'b0;
        asg_we      = 1'b0;
        asg_drop    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    case (i_in_data.kind)
                        KIND_EDGE: begin
                            edge_we = (NODE_CFG_W'(i_in_data.node_a) < NODE_CFG_W'(eff_n))
                                   && (NODE_CFG_W'(i_in_data.node_b) < NODE_CFG_W'(eff_n));
                        end
                        KIND_CLEAR: begin
                            adj_clr = 1'b1;
                        end
                        KIND_SOLVE: begin
                            asg_start = 1'b1;
                            n_pos     = '0;
                            n_color   = '0;
                            n_state   = ST_SEARCH;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SEARCH: begin
                if (r_pos >= eff_n) begin
                    n_found = 1'b1;
                    n_pos   = '0;
                    n_state = ST_EMIT;
                end else if (r_color >= eff_m) begin
                    if (r_pos == '0) begin
                        n_found = 1'b0;
                        n_state = ST_EMIT;
                    end else begin
                        // step back, resume one colour past the old choice
                        asg_drop = 1'b1;
                        n_pos    = pos_m1;
                        n_color  = {1'b0, rd_color} + 1'b1;
                    end
                end else if (!conflict) begin
                    asg_we  = 1'b1;
                    n_pos   = r_pos + 1'b1;
                    n_color = '0;
                end else begin
                    n_color = r_color + 1'b1;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    if (!r_found) begin
                        n_out.node_index = '0;
                        n_out.node_color = '0;
                        n_out.found      = 1'b0;
                        n_out.last       = 1'b1;
                        n_state          = ST_IDLE;
                    end else begin
                        n_out.node_index = NODE_FIELD_W'(pos_idx);
                        n_out.node_color = COLOR_FIELD_W'(rd_color);
                        n_out.found      = 1'b1;
                        n_out.last       = (t_npos'(r_pos + 1'b1) == eff_n);
                        n_pos            = r_pos + 1'b1;
                        if (n_out.last) begin
                            n_state = ST_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_out_valid   <= 1'b0;
            r_node_count  <= NODE_CFG_W'(1);
            r_color_count <= COLOR_CFG_W'(1);
            r_pos         <= '0;
            r_assigned    <= '0;
            for (int i = 0; i < NODE_LIMIT; i++) begin
                r_adj[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_pos       <= n_pos;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_NODE_COUNT:  r_node_count  <= i_cfg_data[NODE_CFG_W-1:0];
                    CFG_COLOR_COUNT: r_color_count <= i_cfg_data[COLOR_CFG_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (adj_clr) begin
                for (int i = 0; i < NODE_LIMIT; i++) begin
                    r_adj[i] <= '0;
                end
            end else if (edge_we) begin
                // undirected: both directions stored
                r_adj[i_in_data.node_a[NODE_W-1:0]][i_in_data.node_b[NODE_W-1:0]] <= 1'b1;
                r_adj[i_in_data.node_b[NODE_W-1:0]][i_in_data.node_a[NODE_W-1:0]] <= 1'b1;
            end
            if (asg_start) begin
                r_assigned <= '0;
            end else if (asg_we) begin
                r_assigned[pos_idx] <= 1'b1;
            end else if (asg_drop) begin
                r_assigned[pos_m1[NODE_W-1:0]] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_color <= n_color;
        r_found <= n_found;
        r_out   <= n_out;
        if (asg_we) begin
            r_assign[pos_idx] <= r_color[COLOR_W-1:0];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

/* rtl/gcb_checker.sv */
// Port-level checks for the graph colouring block, bound to its top level.
// Depends on gcb_pkg for the transfer structs and kind codes.
module gcb_checker
    import gcb_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_ready,
    input t_in_item              i_in_data,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input t_out_item             o_out_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // not-found is a single, zeroed, final result
    a_not_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.found |->
            o_out_data.last && (o_out_data.node_index == '0) && (o_out_data.node_color == '0))
        else $error("malformed not-found result");

    // input stays stalled while a run's results are still coming
    a_busy_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.last |-> !o_in_ready)
        else $error("input ready mid-run");

    // a solve transfer always stalls the input in the following cycle
    a_solve_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_in_data.kind == KIND_SOLVE) |=> !o_in_ready)
        else $error("ready straight after solve");

endmodule

bind graph_coloring_backtrack gcb_checker u_gcb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

/* test/tb_graph_coloring_backtrack.sv */
// Self-checking testbench for graph_coloring_backtrack: edge loads, clears and solves.
// Holds its own backtracking predictor and checks every result transfer in order.
// Depends on gcb_pkg and the graph_coloring_backtrack top level.
module tb_graph_coloring_backtrack;
    timeunit 1ns;
    timeprecision 1ps;

    import gcb_pkg::*;

    localparam logic [1:0] KIND_UNUSED  = 2'd3;
    localparam int         SETTLE_CYCLES = 8;
    localparam int         SOLVE_BUDGET  = 2000;   // search steps allowed per random solve
    localparam int         MAX_PRINTS    = 50;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    t_cfg_reg              i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_ready;
    t_in_item              i_in_data;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_item             o_out_data;

    graph_coloring_backtrack u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // Predictor state
    logic [31:0] adj_rows [32];
    logic [5:0]  node_cnt_reg;
    logic [4:0]  colour_cnt_reg;
    logic [3:0]  trial_colour [32];
    logic [31:0] trial_mask;
    t_out_item   colour_results [$];
    t_out_item   oldest_colour;

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int n_errors       = 0;
    int n_items        = 0;
    int n_solves       = 0;
    int n_found        = 0;
    int n_unsolvable   = 0;
    int n_results      = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #30ms;
        $display("timeout waiting for the block");
        $display("== FAIL ==");
        $finish;
    end

    function automatic int eff_node_count();
        int n;
        n = node_cnt_reg;
        if (n == 0) n = 1;
        if (n > NODE_LIMIT) n = NODE_LIMIT;
        return n;
    endfunction

    function automatic int eff_colour_count();
        int m;
        m = colour_cnt_reg;
        if (m > MAX_COLORS) m = MAX_COLORS;
        return m;
    endfunction

    // Self loops never block: the node under test is not in the mask yet.
    function automatic bit colour_is_safe(input int node, input int c, input int n);
        for (int i = 0; i < n; i++) begin
            if (adj_rows[node][i] && trial_mask[i] && trial_colour[i] == c) return 1'b0;
        end
        return 1'b1;
    endfunction

    // 1: colouring found, 0: none exists, -1: step budget used up.
    function automatic int search_colouring(input int n, input int m, input int budget);
        int pos;
        int c;
        int steps;
        bit placed;
        int next_try [33];
        pos = 0;
        steps = 0;
        trial_mask = '0;
        for (int i = 0; i < 33; i++) next_try[i] = 0;
        for (int i = 0; i < 32; i++) trial_colour[i] = '0;
        while (pos < n) begin
            placed = 1'b0;
            c = next_try[pos];
            while (!placed && c < m) begin
                steps++;
                if (colour_is_safe(pos, c, n)) begin
                    trial_colour[pos] = c[3:0];
                    trial_mask[pos]   = 1'b1;
                    next_try[pos]     = c + 1;
                    pos++;
                    next_try[pos]     = 0;
                    placed = 1'b1;
                end else begin
                    c++;
                end
            end
            if (!placed) begin
                if (pos == 0) return 0;
                pos--;
                trial_mask[pos] = 1'b0;
                steps++;
            end
            if (steps > budget) return -1;
        end
        return 1;
    endfunction

    function automatic void apply_graph_item(input t_in_item item);
        int n;
        t_out_item res;
        n = eff_node_count();
        case (item.kind)
            KIND_EDGE: begin
                if (item.node_a < n && item.node_b < n) begin
                    adj_rows[item.node_a][item.node_b] = 1'b1;
                    adj_rows[item.node_b][item.node_a] = 1'b1;
                end
            end
            KIND_CLEAR: begin
                for (int i = 0; i < 32; i++) adj_rows[i] = '0;
            end
            KIND_SOLVE: begin
                n_solves++;
                if (search_colouring(n, eff_colour_count(), 1 << 30) == 1) begin
                    n_found++;
                    for (int i = 0; i < n; i++) begin
                        res.node_index = i[NODE_FIELD_W-1:0];
                        res.node_color = trial_colour[i];
                        res.found      = 1'b1;
                        res.last       = (i == n - 1);
                        colour_results.push_back(res);
                    end
                end else begin
                    n_unsolvable++;
                    res      = '0;
                    res.last = 1'b1;
                    colour_results.push_back(res);
                end
            end
            default: ;
        endcase
    endfunction

    function automatic t_in_item make_item(input logic [1:0] kind, input int a, input int b);
        t_in_item it;
        it.kind   = t_kind'(kind);
        it.node_a = a[NODE_FIELD_W-1:0];
        it.node_b = b[NODE_FIELD_W-1:0];
        return it;
    endfunction

    task automatic report_mismatch(input string msg);
        n_errors++;
        if (n_errors <= MAX_PRINTS) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // Entered just after a rising edge; returns at the edge that takes the transfer.
    task automatic send_item(input t_in_item item);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        n_items++;
        apply_graph_item(item);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (colour_results.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_config(input int n_val, input int c_val);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_NODE_COUNT;
        i_cfg_data <= n_val[CFG_DATA_W-1:0];
        @(negedge i_clk);
        i_cfg_idx  <= CFG_COLOR_COUNT;
        i_cfg_data <= c_val[CFG_DATA_W-1:0];
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        node_cnt_reg   = n_val[NODE_CFG_W-1:0];
        colour_cnt_reg = c_val[COLOR_CFG_W-1:0];
    endtask

    // Result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            n_results++;
            if (colour_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result node %0d colour %0d found %0d last %0d",
                    o_out_data.node_index, o_out_data.node_color, o_out_data.found,
                    o_out_data.last));
            end else begin
                oldest_colour = colour_results.pop_front();
                if (o_out_data !== oldest_colour)
                    report_mismatch($sformatf(
                        "got node %0d colour %0d found %0d last %0d, want %0d %0d %0d %0d",
                        o_out_data.node_index, o_out_data.node_color, o_out_data.found,
                        o_out_data.last, oldest_colour.node_index, oldest_colour.node_color,
                        oldest_colour.found, oldest_colour.last));
            end
        end
    end

    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    task automatic test_lone_node();
        send_item(make_item(KIND_SOLVE, 0, 0));
    endtask

    // zero nodes acts as one; zero colours can never succeed
    task automatic test_degenerate_counts();
        set_config(0, 0);
        send_item(make_item(KIND_SOLVE, 31, 31));
        set_config(0, 1);
        send_item(make_item(KIND_EDGE, 0, 0));
        send_item(make_item(KIND_EDGE, 1, 0));
        send_item(make_item(KIND_SOLVE, 0, 0));
    endtask

    // oversized counts saturate to the full node and colour range
    task automatic test_full_width();
        set_config(63, 31);
        send_item(make_item(KIND_EDGE, 0, 31));
        send_item(make_item(KIND_EDGE, 5, 5));
        send_item(make_item(KIND_EDGE, 31, 30));
        send_item(make_item(KIND_EDGE, 30, 0));
        send_item(make_item(KIND_SOLVE, 0, 0));
    endtask

    task automatic test_odd_cycle();
        set_config(3, 2);
        send_item(make_item(KIND_CLEAR, 0, 0));
        send_item(make_item(KIND_EDGE, 0, 1));
        send_item(make_item(KIND_EDGE, 1, 2));
        send_item(make_item(KIND_EDGE, 2, 0));
        send_item(make_item(KIND_EDGE, 3, 0));
        send_item(make_item(KIND_UNUSED, 31, 31));
        send_item(make_item(KIND_SOLVE, 0, 0));
        set_config(3, 3);
        send_item(make_item(KIND_SOLVE, 0, 0));
    endtask

    // edge beyond a shrunk node count is kept but ignored until the count grows back
    task automatic test_stale_edges();
        set_config(4, 1);
        send_item(make_item(KIND_CLEAR, 0, 0));
        send_item(make_item(KIND_EDGE, 2, 3));
        set_config(3, 1);
        send_item(make_item(KIND_SOLVE, 0, 0));
        set_config(4, 1);
        send_item(make_item(KIND_SOLVE, 0, 0));
    endtask

    task automatic test_random_graphs();
        int start;
        int pick;
        int n_sel;
        int c_sel;
        int n;
        for (int ph = 0; ph < 4; ph++) begin
            src_idle_pct   = (ph == 1) ? 74 : (ph == 3) ? 15 : 0;
            sink_stall_pct = (ph == 2) ? 74 : (ph == 3) ? 15 : 0;
            start = n_items;
            while (n_items - start < 50) begin
                pick = $urandom_range(99);
                if (pick < 65)      n_sel = $urandom_range(2, 8);
                else if (pick < 85) n_sel = $urandom_range(9, 20);
                else if (pick < 93) n_sel = $urandom_range(32, 63);
                else                n_sel = $urandom_range(0, 1);
                pick = $urandom_range(99);
                if (pick < 80) c_sel = $urandom_range(1, 4);
                else           c_sel = $urandom_range(0, 31);
                c_sel = c_sel | ($urandom_range(1) << 5);
                set_config(n_sel, c_sel);
                n = eff_node_count();
                repeat ($urandom_range(1, 3)) begin
                    if ($urandom_range(3) != 0) send_item(make_item(KIND_CLEAR, 0, 0));
                    repeat ($urandom_range(0, 2 * n)) begin
                        pick = $urandom_range(99);
                        if (pick < 85)
                            send_item(make_item(KIND_EDGE, $urandom_range(n - 1),
                                                $urandom_range(n - 1)));
                        else if (pick < 95)
                            send_item(make_item(KIND_EDGE, $urandom_range(31),
                                                $urandom_range(31)));
                        else
                            send_item(make_item(KIND_UNUSED, $urandom_range(31),
                                                $urandom_range(31)));
                    end
                    // keep the search short: wipe graphs that would backtrack for too long
                    if (search_colouring(n, eff_colour_count(), SOLVE_BUDGET) < 0)
                        send_item(make_item(KIND_CLEAR, $urandom_range(31), $urandom_range(31)));
                    send_item(make_item(KIND_SOLVE, $urandom_range(31), $urandom_range(31)));
                end
            end
        end
        src_idle_pct   = 0;
        sink_stall_pct = 0;
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = CFG_NODE_COUNT;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        for (int i = 0; i < 32; i++) adj_rows[i] = '0;
        node_cnt_reg   = 6'd1;
        colour_cnt_reg = 5'd1;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_lone_node();
        test_degenerate_counts();
        test_full_width();
        test_odd_cycle();
        test_stale_edges();
        test_random_graphs();
        wait_idle();

        $display("Covered %0d transfers in: %0d solves (%0d coloured, %0d without colouring)",
                 n_items, n_solves, n_found, n_unsolvable);
        $display("Checked %0d result transfers over four handshake pressure phases, %0d errors",
                 n_results, n_errors);
        if (n_errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
